[sv/ppi_pkg.sv]
// Types and constants shared by the PPI port interface with sound-chip bridge.
package ppi_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] PORT_A    = 2'd0;
  localparam logic [1:0] PORT_B    = 2'd1;
  localparam logic [1:0] PORT_C    = 2'd2;
  localparam logic [1:0] PORT_CTRL = 2'd3;

  localparam logic [1:0] SND_INACTIVE = 2'd0;
  localparam logic [1:0] SND_READ     = 2'd1;
  localparam logic [1:0] SND_WRITE    = 2'd2;
  localparam logic [1:0] SND_LATCH    = 2'd3;

  localparam logic [7:0] KEY_REGISTER = 8'd14;
  localparam logic [7:0] BUSY_LIMIT   = 8'd6;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] UPPER_MASK   = 8'hF0;
  localparam logic [7:0] LOWER_MASK   = 8'h0F;

  localparam logic [2:0] MAKER_RESET   = 3'd7;
  localparam logic       REFRESH_RESET = 1'b1;

  localparam logic CFG_MAKER   = 1'b0;
  localparam logic CFG_REFRESH = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] port_select;
    logic [7:0] write_data;
    logic       vsync;
    logic       tape_in;
    logic [7:0] port_c_pins;
    logic [7:0] keyboard_row_data;
    logic [7:0] psg_read_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_out;
    logic [7:0] port_c_out;
    logic [3:0] keyboard_row;
    logic       psg_write;
    logic [7:0] psg_register;
    logic [7:0] psg_write_data;
    logic       psg_read_request;
    logic       sound_busy_pulse;
    logic       keyboard_scanned;
  } out_item_t;

  typedef struct packed {
    logic [7:0] port_a_latch;
    logic [7:0] port_c_latch;
    logic       port_a_is_input;
    logic       port_c_upper_input;
    logic       port_c_lower_input;
    logic [7:0] sound_register_select;
    logic [1:0] sound_bus_mode;
    logic [3:0] key_row_select;
    logic       scanned_flag;
  } ppi_state_t;

  typedef struct packed {
    logic [2:0] manufacturer_code;
    logic       refresh_50hz;
  } ppi_cfg_t;

endpackage

[sv/ppi_if.sv]
// Valid/ready channel interfaces for PPI request and result items.
interface ppi_in_if;
  logic                valid;
  logic                ready;
  ppi_pkg::in_item_t   item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ppi_out_if;
  logic                valid;
  logic                ready;
  ppi_pkg::out_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[sv/ppi_step.sv]
// Next-state and result logic for one PPI bus access or flag clear.
module ppi_step (
  input  ppi_pkg::in_item_t   item,
  input  ppi_pkg::ppi_state_t state,
  input  ppi_pkg::ppi_cfg_t   cfg,
  output ppi_pkg::ppi_state_t state_next,
  output ppi_pkg::out_item_t  result
);

  logic [7:0] mask_a;
  logic [7:0] mask_c;
  logic [7:0] drive_a;
  logic [7:0] drive_c_new;
  logic [7:0] bit_sel;
  logic [7:0] a_next_drive;
  logic [7:0] c_next_mask;
  logic [1:0] bridge_mode;
  logic       bridge_en;

  always_comb begin
    mask_a = state.port_a_is_input ? 8'hFF : 8'h00;
    mask_c = (state.port_c_upper_input ? ppi_pkg::UPPER_MASK : 8'h00)
           | (state.port_c_lower_input ? ppi_pkg::LOWER_MASK : 8'h00);
    drive_a = state.port_a_latch | mask_a;
    drive_c_new = item.write_data | mask_c;
    bit_sel = 8'd1 << item.write_data[3:1];

    state_next = state;
    result.read_data = ppi_pkg::IDLE_BYTE;
    result.psg_write = 1'b0;
    result.psg_read_request = 1'b0;
    result.sound_busy_pulse = 1'b0;
    bridge_en = 1'b0;
    bridge_mode = state.sound_bus_mode;

    unique case (item.kind)
      ppi_pkg::KIND_WRITE: begin
        unique case (item.port_select)
          ppi_pkg::PORT_A: begin
            state_next.port_a_latch = item.write_data;
            bridge_en = 1'b1;
          end
          ppi_pkg::PORT_B: begin
          end
          ppi_pkg::PORT_C: begin
            state_next.port_c_latch = item.write_data;
            state_next.key_row_select = drive_c_new[3:0];
            state_next.sound_bus_mode = drive_c_new[7:6];
            bridge_mode = drive_c_new[7:6];
            bridge_en = 1'b1;
          end
          ppi_pkg::PORT_CTRL: begin
            if (item.write_data[7]) begin
              state_next.port_a_latch = 8'h00;
              state_next.port_c_latch = 8'h00;
              state_next.port_a_is_input = item.write_data[4];
              state_next.port_c_lower_input = item.write_data[0];
              state_next.port_c_upper_input = item.write_data[3];
            end else if (item.write_data[0]) begin
              state_next.port_c_latch = state.port_c_latch | bit_sel;
            end else begin
              state_next.port_c_latch = state.port_c_latch & ~bit_sel;
            end
          end
          default: begin
          end
        endcase
      end
      ppi_pkg::KIND_READ: begin
        unique case (item.port_select)
          ppi_pkg::PORT_A: begin
            if (state.sound_bus_mode == ppi_pkg::SND_READ) begin
              if (state.sound_register_select == ppi_pkg::KEY_REGISTER) begin
                state_next.scanned_flag = 1'b1;
                result.read_data = item.keyboard_row_data;
              end else begin
                result.read_data = item.psg_read_data;
                result.psg_read_request = 1'b1;
              end
            end
          end
          ppi_pkg::PORT_B: begin
            result.read_data = {item.tape_in, 2'b00, cfg.refresh_50hz,
                                cfg.manufacturer_code, item.vsync};
          end
          ppi_pkg::PORT_C: begin
            result.read_data = (item.port_c_pins & mask_c) | (state.port_c_latch & ~mask_c);
          end
          ppi_pkg::PORT_CTRL: begin
          end
          default: begin
          end
        endcase
      end
      ppi_pkg::KIND_CLEAR: begin
        state_next.scanned_flag = 1'b0;
      end
      ppi_pkg::KIND_NONE: begin
      end
      default: begin
      end
    endcase

    // sound bridge: latch takes the port A drive as it stands after this item
    if (bridge_en) begin
      if (bridge_mode == ppi_pkg::SND_WRITE) begin
        result.psg_write = 1'b1;
        result.sound_busy_pulse = (state.sound_register_select < ppi_pkg::BUSY_LIMIT);
      end else if (bridge_mode == ppi_pkg::SND_LATCH) begin
        state_next.sound_register_select = (item.port_select == ppi_pkg::PORT_A)
                                         ? (item.write_data | mask_a) : drive_a;
      end
    end

    a_next_drive = state_next.port_a_latch | (state_next.port_a_is_input ? 8'hFF : 8'h00);
    c_next_mask = (state_next.port_c_upper_input ? ppi_pkg::UPPER_MASK : 8'h00)
                | (state_next.port_c_lower_input ? ppi_pkg::LOWER_MASK : 8'h00);
    result.port_a_out = a_next_drive;
    result.port_c_out = state_next.port_c_latch | c_next_mask;
    result.keyboard_row = state_next.key_row_select;
    result.psg_register = state_next.sound_register_select;
    result.psg_write_data = a_next_drive;
    result.keyboard_scanned = state_next.scanned_flag;
  end

endmodule

[sv/ppi_port_interface_with_psg_bridge.sv]
// Top level: PPI port interface with sound-chip bridge, item pipeline and config registers.
// The block takes one item per clock while the output side keeps up, and returns one
// result item for each. An accepted item sits in the input register; when the result
// register is free or being taken, the shallow step logic updates the port latches and
// bridge state and loads the result register, which offers the result until it is taken.
// The result register parts the two sides; when it is held, the input register fills and
// ready drops until it drains.
// Configuration writes take effect at the next clock edge and are read back in port B reads.
module ppi_port_interface_with_psg_bridge (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  ppi_in_if.sink     req,
  ppi_out_if.source  rsp
);

  ppi_pkg::in_item_t   item_q;
  logic                item_valid;
  ppi_pkg::ppi_state_t state;
  ppi_pkg::ppi_state_t state_next;
  ppi_pkg::ppi_cfg_t   cfg;
  ppi_pkg::out_item_t  result;
  ppi_pkg::out_item_t  result_next;
  logic                result_valid;
  logic                advance;

  assign advance   = item_valid && (!result_valid || rsp.ready);
  assign req.ready = !item_valid || advance;
  assign rsp.valid = result_valid;
  assign rsp.item  = result;

  ppi_step u_step (
    .item       (item_q),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      result_valid <= 1'b0;
      state <= '0;
      cfg.manufacturer_code <= ppi_pkg::MAKER_RESET;
      cfg.refresh_50hz <= ppi_pkg::REFRESH_RESET;
    end else begin
      if (req.valid && req.ready) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state <= state_next;
      end else if (rsp.ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ppi_pkg::CFG_MAKER:   cfg.manufacturer_code <= cfg_data;
          ppi_pkg::CFG_REFRESH: cfg.refresh_50hz <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_q <= req.item;
    end
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

[tb/sv/ppi_result_checker.sv]
// Checker for the PPI port block: predicts each result item from accepted requests and compares.
module ppi_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  ppi_in_if          req,
  ppi_out_if         rsp,
  output int         fail_count,
  output int         pending
);

  logic [7:0] a_latch;
  logic [7:0] c_latch;
  logic       a_in;
  logic       c_hi_in;
  logic       c_lo_in;
  logic [7:0] snd_reg;
  logic [1:0] snd_mode;
  logic [3:0] row_sel;
  logic       scanned;
  logic [2:0] maker;
  logic       refresh;

  ppi_pkg::out_item_t expected_q[$];
  ppi_pkg::out_item_t want;
  ppi_pkg::out_item_t got;
  int                 result_no;

  function automatic logic [7:0] a_drive();
    return a_latch | {8{a_in}};
  endfunction

  function automatic logic [7:0] c_mask();
    return (c_hi_in ? ppi_pkg::UPPER_MASK : 8'h00) | (c_lo_in ? ppi_pkg::LOWER_MASK : 8'h00);
  endfunction

  function automatic void sound_bridge(inout ppi_pkg::out_item_t r);
    if (snd_mode == ppi_pkg::SND_WRITE) begin
      r.psg_write = 1'b1;
      r.sound_busy_pulse = (snd_reg < ppi_pkg::BUSY_LIMIT);
    end else if (snd_mode == ppi_pkg::SND_LATCH) begin
      snd_reg = a_drive();
    end
  endfunction

  function automatic ppi_pkg::out_item_t step_ppi(input ppi_pkg::in_item_t it);
    ppi_pkg::out_item_t r;
    logic [7:0]         c_drive;
    r = '0;
    r.read_data = ppi_pkg::IDLE_BYTE;
    case (it.kind)
      ppi_pkg::KIND_WRITE: begin
        case (it.port_select)
          ppi_pkg::PORT_A: begin
            a_latch = it.write_data;
            sound_bridge(r);
          end
          ppi_pkg::PORT_C: begin
            c_latch = it.write_data;
            c_drive = c_latch | c_mask();
            row_sel = c_drive[3:0];
            snd_mode = c_drive[7:6];
            sound_bridge(r);
          end
          ppi_pkg::PORT_CTRL: begin
            if (it.write_data[7]) begin
              a_latch = '0;
              c_latch = '0;
              a_in = it.write_data[4];
              c_lo_in = it.write_data[0];
              c_hi_in = it.write_data[3];
            end else begin
              c_latch[it.write_data[3:1]] = it.write_data[0];
            end
          end
          default: ;
        endcase
      end
      ppi_pkg::KIND_READ: begin
        case (it.port_select)
          ppi_pkg::PORT_A: begin
            if (snd_mode == ppi_pkg::SND_READ) begin
              if (snd_reg == ppi_pkg::KEY_REGISTER) begin
                scanned = 1'b1;
                r.read_data = it.keyboard_row_data;
              end else begin
                r.read_data = it.psg_read_data;
                r.psg_read_request = 1'b1;
              end
            end
          end
          ppi_pkg::PORT_B: r.read_data = {it.tape_in, 2'b00, refresh, maker, it.vsync};
          ppi_pkg::PORT_C: r.read_data = (it.port_c_pins & c_mask()) | (c_latch & ~c_mask());
          default: ;
        endcase
      end
      ppi_pkg::KIND_CLEAR: scanned = 1'b0;
      default: ;
    endcase
    r.port_a_out = a_drive();
    r.port_c_out = c_latch | c_mask();
    r.keyboard_row = row_sel;
    r.psg_register = snd_reg;
    r.psg_write_data = a_drive();
    r.keyboard_scanned = scanned;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on result %0d, %s: expected %02h, got %02h",
                 result_no, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      a_latch = '0;
      c_latch = '0;
      a_in = 1'b0;
      c_hi_in = 1'b0;
      c_lo_in = 1'b0;
      snd_reg = '0;
      snd_mode = ppi_pkg::SND_INACTIVE;
      row_sel = '0;
      scanned = 1'b0;
      maker = ppi_pkg::MAKER_RESET;
      refresh = ppi_pkg::REFRESH_RESET;
      expected_q.delete();
      fail_count = 0;
      result_no = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppi_pkg::CFG_MAKER:   maker = cfg_data;
          ppi_pkg::CFG_REFRESH: refresh = cfg_data[0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.item;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with nothing outstanding: %h", result_no, got);
        end else begin
          want = expected_q.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("port_a_out", want.port_a_out, got.port_a_out);
          check_field("port_c_out", want.port_c_out, got.port_c_out);
          check_field("keyboard_row", 8'(want.keyboard_row), 8'(got.keyboard_row));
          check_field("psg_write", 8'(want.psg_write), 8'(got.psg_write));
          check_field("psg_register", want.psg_register, got.psg_register);
          check_field("psg_write_data", want.psg_write_data, got.psg_write_data);
          check_field("psg_read_request", 8'(want.psg_read_request),
                      8'(got.psg_read_request));
          check_field("sound_busy_pulse", 8'(want.sound_busy_pulse),
                      8'(got.sound_busy_pulse));
          check_field("keyboard_scanned", 8'(want.keyboard_scanned),
                      8'(got.keyboard_scanned));
        end
        result_no++;
      end
      if (req.valid && req.ready)
        expected_q.push_back(step_ppi(req.item));
    end
    pending = expected_q.size();
  end

endmodule

[tb/sv/tb_ppi_port_interface_with_psg_bridge.sv]
// Testbench top for the PPI port block: clock, reset, request and result traffic, verdict.
module tb_ppi_port_interface_with_psg_bridge;

  localparam int         HOLD_CYCLES     = 100;
  localparam int         ITEMS_PER_PHASE = 330;
  localparam logic [7:0] MODE_SET        = 8'h80;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [2:0] cfg_data;
  int         fail_count;
  int         pending;
  int         sent_count;
  bit         steady;
  bit         squeeze;

  ppi_in_if  req_ch ();
  ppi_out_if rsp_ch ();

  ppi_port_interface_with_psg_bridge uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  ppi_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic ppi_pkg::in_item_t make_item(input logic [1:0] kind,
                                                  input logic [1:0] port,
                                                  input logic [7:0] wd);
    ppi_pkg::in_item_t it;
    it.kind = kind;
    it.port_select = port;
    it.write_data = wd;
    it.vsync = 1'($urandom);
    it.tape_in = 1'($urandom);
    it.port_c_pins = 8'($urandom);
    it.keyboard_row_data = 8'($urandom);
    it.psg_read_data = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input ppi_pkg::in_item_t it);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.item <= it;
    do @(posedge clk); while (!req_ch.ready);
    if (!(it.kind == ppi_pkg::KIND_NONE ||
          (it.kind == ppi_pkg::KIND_WRITE && it.port_select == ppi_pkg::PORT_B)))
      sent_count++;
  endtask

  task automatic put(input logic [1:0] kind, input logic [1:0] port, input logic [7:0] wd);
    send_item(make_item(kind, port, wd));
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] maker, input logic refresh);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= ppi_pkg::CFG_MAKER;
    cfg_data <= maker;
    @(posedge clk);
    cfg_index <= ppi_pkg::CFG_REFRESH;
    cfg_data <= {2'b00, refresh};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int target);
    int         pick;
    logic [3:0] row;
    logic [7:0] reg_no;
    while (sent_count < target) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        row = 4'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2:    reg_no = ppi_pkg::KEY_REGISTER;
          3, 4, 5, 6: reg_no = 8'($urandom_range(0, 5));
          default:    reg_no = 8'($urandom);
        endcase
        put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_LATCH, 2'($urandom), row});
        put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, reg_no);
        put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_INACTIVE, 2'($urandom), row});
        if ($urandom_range(0, 1)) begin
          put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'($urandom));
          put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_WRITE, 2'($urandom), row});
        end else begin
          put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_READ, 2'($urandom), row});
          repeat ($urandom_range(1, 2))
            put(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'($urandom));
          if ($urandom_range(0, 3) == 0)
            put(ppi_pkg::KIND_CLEAR, ppi_pkg::PORT_A, 8'($urandom));
        end
        put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_INACTIVE, 2'($urandom), row});
      end else if (pick < 75) begin
        put(2'($urandom), 2'($urandom), 8'($urandom));
      end else if (pick < 87) begin
        if ($urandom_range(0, 1)) begin
          put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, MODE_SET | 8'($urandom));
          put(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'($urandom));
          if ($urandom_range(0, 9) < 7) put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, MODE_SET);
        end else begin
          put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'($urandom) & ~MODE_SET);
        end
      end else begin
        put(ppi_pkg::KIND_READ, $urandom_range(0, 1) ? ppi_pkg::PORT_B : ppi_pkg::PORT_C,
            8'($urandom));
      end
    end
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else if (steady || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat (idle_span()) @(posedge clk);
      end
    end
  end

  initial begin
    #(12 * 600000);
    $display("FAIL");
    $finish;
  end

  initial begin
    ppi_pkg::in_item_t probe;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= ppi_pkg::CFG_MAKER;
    cfg_data <= '0;
    steady = 1'b0;
    squeeze = 1'b0;
    sent_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    probe = make_item(ppi_pkg::KIND_READ, ppi_pkg::PORT_B, 8'h00);
    probe.vsync = 1'b0;
    probe.tape_in = 1'b0;
    send_item(probe);
    probe.vsync = 1'b1;
    probe.tape_in = 1'b1;
    send_item(probe);
    put(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'h00);
    put(ppi_pkg::KIND_READ, ppi_pkg::PORT_CTRL, 8'hFF);
    put(ppi_pkg::KIND_NONE, ppi_pkg::PORT_A, 8'hFF);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_B, 8'hFF);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'hFF);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'h00);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h9B);
    put(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'h00);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, 8'h00);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, MODE_SET);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_LATCH, 6'h00});
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, ppi_pkg::KEY_REGISTER);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_READ, 6'h05});
    put(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'h00);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'h77);
    put(ppi_pkg::KIND_CLEAR, ppi_pkg::PORT_A, 8'h00);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_LATCH, 6'h00});
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'h03);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_WRITE, 6'h00});
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'hA5);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_LATCH, 6'h00});
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, ppi_pkg::BUSY_LIMIT);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_WRITE, 6'h0F});
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, {ppi_pkg::SND_READ, 6'h0A});
    put(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'h00);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h0F);
    put(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h00);
    put(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'h00);

    run_random(ITEMS_PER_PHASE);
    set_config(3'd0, 1'b0);
    run_random(2 * ITEMS_PER_PHASE);
    set_config(3'($urandom), 1'b1);
    // hold the result side off while requests keep coming
    steady = 1'b1;
    squeeze = 1'b1;
    repeat (40) put(2'($urandom_range(0, 2)), 2'($urandom), 8'($urandom));
    steady = 1'b0;
    run_random(3 * ITEMS_PER_PHASE);
    set_config(3'd7, 1'b0);
    run_random(4 * ITEMS_PER_PHASE);
    settle();

    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
